>>> rtl/sqh_pkg.sv
// shared types and constants for the square-to-quad homography core
`timescale 1ns / 1ps
package sqh_pkg;
    localparam int COORD_W = 32;
    localparam int DIFF_W  = 34;
    localparam int PROD_W  = 68;
    localparam int DET_W   = 69;
    localparam int QUO_W   = 31;
    localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [DET_W-1:0]   t_wide;

    function automatic t_coord sat_coord(input logic signed [71:0] v);
        if (v > 72'(signed'(SAT_MAX))) begin
            return SAT_MAX;
        end else if (v < 72'(signed'(SAT_MIN))) begin
            return SAT_MIN;
        end else begin
            return v[COORD_W-1:0];
        end
    endfunction
endpackage

>>> rtl/sqh_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating
`timescale 1ns / 1ps
module sqh_div #(
    parameter int FRAC_BITS = 16,
    parameter int TAG_W     = 1
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [68:0]       i_num,
    input  logic signed [68:0]       i_den,
    input  logic [TAG_W-1:0]         i_tag,
    output logic signed [31:0]       o_quo,
    output logic [TAG_W-1:0]         o_tag
);
    import sqh_pkg::*;
    localparam int DW = 69 + 31;
    localparam int NS = QUO_W + 1;

    logic [DW-1:0]      r_rem [NS];
    logic [68:0]        r_den [NS];
    logic [QUO_W-1:0]   r_q   [NS];
    logic               r_neg [NS];
    logic               r_sat [NS];
    logic [TAG_W-1:0]   r_tag [NS];

    logic [68:0]   nmag;
    logic [68:0]   dmag;
    logic [DW-1:0] nsh;

    assign nmag = i_num[68] ? 69'(-i_num) : 69'(i_num);
    assign dmag = i_den[68] ? 69'(-i_den) : 69'(i_den);
    assign nsh  = DW'({nmag, {FRAC_BITS{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= nsh;
            r_den[0] <= dmag;
            r_q[0]   <= '0;
            r_neg[0] <= i_num[68] ^ i_den[68];
            r_sat[0] <= nsh >= {dmag, 31'b0};
            r_tag[0] <= i_tag;
            for (int s = 1; s < NS; s++) begin
                logic [DW-1:0] t;
                t = DW'(r_den[s-1]) << (QUO_W - s);
                r_den[s] <= r_den[s-1];
                r_neg[s] <= r_neg[s-1];
                r_sat[s] <= r_sat[s-1];
                r_tag[s] <= r_tag[s-1];
                if (r_rem[s-1] >= t) begin
                    r_rem[s] <= r_rem[s-1] - t;
                    r_q[s]   <= r_q[s-1] | (QUO_W'(1) << (QUO_W - s));
                end else begin
                    r_rem[s] <= r_rem[s-1];
                    r_q[s]   <= r_q[s-1];
                end
            end
        end
    end

    always_comb begin
        if (r_sat[NS-1]) begin
            o_quo = r_neg[NS-1] ? SAT_MIN : SAT_MAX;
        end else if (r_neg[NS-1]) begin
            o_quo = -$signed({1'b0, r_q[NS-1]});
        end else begin
            o_quo = $signed({1'b0, r_q[NS-1]});
        end
    end
    assign o_tag = r_tag[NS-1];
endmodule

>>> rtl/square_to_quad_homography_core.sv
// top level of the square-to-quad projective matrix core
`timescale 1ns / 1ps
// square_to_quad_homography_core
// input channel: eight signed corner coordinates, one word per quad, taken
// when i_valid is high and o_stall is low
// output channel: the eight matrix terms and a degenerate flag, taken when
// o_valid is high and i_stall is low
// from acceptance to o_valid a word passes the differences, the 34x34
// products of the determinant and numerators, the 32-stage restoring divider
// for g and h, then the g/h scaled products and saturation
// throughput is one word per cycle unless the output is held; the whole
// pipeline advances together and a held output word freezes every stage, so
// o_stall follows i_stall while the output register holds data
// a zero determinant yields the identity matrix with degenerate set
// reset clears the stage valid bits; payload registers are not reset
module square_to_quad_homography_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  sqh_pkg::t_coord       i_corner0_x,
    input  sqh_pkg::t_coord       i_corner0_y,
    input  sqh_pkg::t_coord       i_corner1_x,
    input  sqh_pkg::t_coord       i_corner1_y,
    input  sqh_pkg::t_coord       i_corner2_x,
    input  sqh_pkg::t_coord       i_corner2_y,
    input  sqh_pkg::t_coord       i_corner3_x,
    input  sqh_pkg::t_coord       i_corner3_y,
    output logic                  o_valid,
    input  logic                  i_stall,
    output sqh_pkg::t_coord       o_coef_a,
    output sqh_pkg::t_coord       o_coef_b,
    output sqh_pkg::t_coord       o_coef_c,
    output sqh_pkg::t_coord       o_coef_d,
    output sqh_pkg::t_coord       o_coef_e,
    output sqh_pkg::t_coord       o_coef_f,
    output sqh_pkg::t_coord       o_coef_g,
    output sqh_pkg::t_coord       o_coef_h,
    output logic                  o_degenerate
);
    import sqh_pkg::*;

    localparam int DIV_LAT = QUO_W + 1;
    localparam int TAG_W   = 1 + 6 * COORD_W;
    localparam int PIPE    = 3 + DIV_LAT + 3;

    logic en;
    assign en = !(o_valid && i_stall);
    assign o_stall = !en;

    logic [PIPE-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE-2:0], i_valid};
        end
    end
    assign o_valid = r_vld[PIPE-1];

    // stage 1: differences
    t_coord r1_x0, r1_y0, r1_x1, r1_y1, r1_x3, r1_y3;
    t_diff  r1_ux, r1_uy, r1_vx, r1_vy, r1_wx, r1_wy;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x0 <= i_corner0_x;
            r1_y0 <= i_corner0_y;
            r1_x1 <= i_corner1_x;
            r1_y1 <= i_corner1_y;
            r1_x3 <= i_corner3_x;
            r1_y3 <= i_corner3_y;
            r1_ux <= DIFF_W'(i_corner1_x) - DIFF_W'(i_corner2_x);
            r1_uy <= DIFF_W'(i_corner1_y) - DIFF_W'(i_corner2_y);
            r1_vx <= DIFF_W'(i_corner3_x) - DIFF_W'(i_corner2_x);
            r1_vy <= DIFF_W'(i_corner3_y) - DIFF_W'(i_corner2_y);
            r1_wx <= DIFF_W'(i_corner0_x) - DIFF_W'(i_corner1_x)
                   + DIFF_W'(i_corner2_x) - DIFF_W'(i_corner3_x);
            r1_wy <= DIFF_W'(i_corner0_y) - DIFF_W'(i_corner1_y)
                   + DIFF_W'(i_corner2_y) - DIFF_W'(i_corner3_y);
        end
    end

    // stage 2: products
    t_coord r2_x0, r2_y0, r2_x1, r2_y1, r2_x3, r2_y3;
    logic signed [PROD_W-1:0] r2_p0, r2_p1, r2_p2, r2_p3, r2_p4, r2_p5;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_x0 <= r1_x0;
            r2_y0 <= r1_y0;
            r2_x1 <= r1_x1;
            r2_y1 <= r1_y1;
            r2_x3 <= r1_x3;
            r2_y3 <= r1_y3;
            r2_p0 <= r1_ux * r1_vy;
            r2_p1 <= r1_vx * r1_uy;
            r2_p2 <= r1_wx * r1_vy;
            r2_p3 <= r1_vx * r1_wy;
            r2_p4 <= r1_ux * r1_wy;
            r2_p5 <= r1_wx * r1_uy;
        end
    end

    // stage 3: determinant and numerators
    t_coord r3_x0, r3_y0, r3_x1, r3_y1, r3_x3, r3_y3;
    t_wide  r3_det, r3_gn, r3_hn;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_x0  <= r2_x0;
            r3_y0  <= r2_y0;
            r3_x1  <= r2_x1;
            r3_y1  <= r2_y1;
            r3_x3  <= r2_x3;
            r3_y3  <= r2_y3;
            r3_det <= DET_W'(r2_p0) - DET_W'(r2_p1);
            r3_gn  <= DET_W'(r2_p2) - DET_W'(r2_p3);
            r3_hn  <= DET_W'(r2_p4) - DET_W'(r2_p5);
        end
    end

    logic              deg3;
    logic [TAG_W-1:0]  tag_in, tag_g;
    logic              tag_h;
    t_coord            q_g, q_h;
    t_wide             den;
    assign deg3   = (r3_det == '0);
    assign den    = deg3 ? DET_W'(1) : r3_det;
    assign tag_in = {deg3, r3_x0, r3_y0, r3_x1, r3_y1, r3_x3, r3_y3};

    sqh_div #(.FRAC_BITS(FRAC_BITS), .TAG_W(TAG_W)) u_div_g (
        .i_clk(i_clk), .i_en(en),
        .i_num(r3_gn), .i_den(den), .i_tag(tag_in),
        .o_quo(q_g), .o_tag(tag_g)
    );
    sqh_div #(.FRAC_BITS(FRAC_BITS), .TAG_W(1)) u_div_h (
        .i_clk(i_clk), .i_en(en),
        .i_num(r3_hn), .i_den(den), .i_tag(deg3),
        .o_quo(q_h), .o_tag(tag_h)
    );

    t_coord dx0, dy0, dx1, dy1, dx3, dy3;
    logic   ddeg;
    assign {ddeg, dx0, dy0, dx1, dy1, dx3, dy3} = tag_g;

    // stage a: scaled products
    t_coord r4_x0, r4_y0, r4_x1, r4_y1, r4_x3, r4_y3, r4_g, r4_h;
    logic   r4_deg;
    logic signed [63:0] r4_ga, r4_gd, r4_hb, r4_he;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_x0  <= dx0;
            r4_y0  <= dy0;
            r4_x1  <= dx1;
            r4_y1  <= dy1;
            r4_x3  <= dx3;
            r4_y3  <= dy3;
            r4_g   <= q_g;
            r4_h   <= q_h;
            r4_deg <= ddeg;
            r4_ga  <= q_g * dx1;
            r4_gd  <= q_g * dy1;
            r4_hb  <= q_h * dx3;
            r4_he  <= q_h * dy3;
        end
    end

    // stage b: sums
    t_coord r5_x0, r5_y0, r5_g, r5_h;
    logic   r5_deg;
    logic signed [71:0] r5_a, r5_b, r5_d, r5_e;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_x0  <= r4_x0;
            r5_y0  <= r4_y0;
            r5_g   <= r4_g;
            r5_h   <= r4_h;
            r5_deg <= r4_deg;
            r5_a   <= 72'(r4_x1) - 72'(r4_x0) + 72'(r4_ga >>> FRAC_BITS);
            r5_d   <= 72'(r4_y1) - 72'(r4_y0) + 72'(r4_gd >>> FRAC_BITS);
            r5_b   <= 72'(r4_x3) - 72'(r4_x0) + 72'(r4_hb >>> FRAC_BITS);
            r5_e   <= 72'(r4_y3) - 72'(r4_y0) + 72'(r4_he >>> FRAC_BITS);
        end
    end

    // output register: saturation and identity select
    localparam t_coord ONE = t_coord'(1) <<< FRAC_BITS;
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_degenerate <= r5_deg;
            if (r5_deg) begin
                o_coef_a <= ONE;
                o_coef_b <= '0;
                o_coef_c <= '0;
                o_coef_d <= '0;
                o_coef_e <= ONE;
                o_coef_f <= '0;
                o_coef_g <= '0;
                o_coef_h <= '0;
            end else begin
                o_coef_a <= sat_coord(r5_a);
                o_coef_b <= sat_coord(r5_b);
                o_coef_c <= r5_x0;
                o_coef_d <= sat_coord(r5_d);
                o_coef_e <= sat_coord(r5_e);
                o_coef_f <= r5_y0;
                o_coef_g <= r5_g;
                o_coef_h <= r5_h;
            end
        end
    end

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(r_vld))
        else $error("pipeline moved while output held");
    a_deg_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_coef_a == ONE && o_coef_g == '0)
        else $error("degenerate word not identity");
    a_tag_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[PIPE-4] |-> tag_g[TAG_W-1] == tag_h)
        else $error("divider tags out of step");
endmodule
